@@ design/rsvg_pkg.sv @@
package rsvg_pkg;

    // Field widths of the channels, fixed by the item format
    localparam int OP_W     = 3;
    localparam int QUBIT_W  = 4;
    localparam int RAND_W   = 16;
    localparam int IDX_W    = 10;
    localparam int OUT_AMP_W = 18;
    localparam int CFG_W    = 4;

    // Qubit counts are handled in this width (it holds counts up to 31)
    localparam int QN_W     = 5;
    localparam int QN_MIN   = 2;
    localparam logic [CFG_W-1:0] QUBIT_COUNT_RESET = 4'd3;

    // 1/sqrt2 with 16 fraction bits, rounding bias and scale shift
    localparam logic signed [16:0] INV_ROOT2 = 17'sd46341;
    localparam int SCALE_SH   = 16;
    localparam int ROUND_BIAS = 32768;

    typedef enum logic [OP_W-1:0] {
        OP_INIT     = 3'd0,
        OP_HADAMARD = 3'd1,
        OP_CNOT     = 3'd2,
        OP_MEASURE  = 3'd3,
        OP_READ     = 3'd4
    } t_opcode;

    // Control toward the pair arithmetic unit
    typedef struct packed {
        logic valid;
        logic swap;
    } t_bf_ctl;

    // Status back from the measurement accumulator
    typedef struct packed {
        logic found;
        logic busy;
    } t_meas_stat;

endpackage

@@ design/rsvg_op_if.sv @@
interface rsvg_op_if import rsvg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [QUBIT_W-1:0]   qubit_a;
    logic [QUBIT_W-1:0]   qubit_b;
    logic [RAND_W-1:0]    random_fraction;
    logic [IDX_W-1:0]     read_index;

    modport source (
        output valid, opcode, qubit_a, qubit_b, random_fraction, read_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, qubit_a, qubit_b, random_fraction, read_index,
        output ready
    );
endinterface

@@ design/rsvg_res_if.sv @@
interface rsvg_res_if import rsvg_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [IDX_W-1:0]            measured_index;
    logic signed [OUT_AMP_W-1:0] amplitude;
    logic                        status;

    modport source (
        output valid, measured_index, amplitude, status,
        input  ready
    );
    modport sink (
        input  valid, measured_index, amplitude, status,
        output ready
    );
endinterface

@@ design/rsvg_store.sv @@
module rsvg_store #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 18
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/rsvg_butterfly.sv @@
module rsvg_butterfly import rsvg_pkg::*; #(
    parameter int AMP_WIDTH = 18,
    parameter int ADDR_W    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_bf_ctl                     i_ctl,
    input  logic signed [AMP_WIDTH-1:0] i_a,
    input  logic signed [AMP_WIDTH-1:0] i_b,
    input  logic [ADDR_W-1:0]           i_addr_a,
    input  logic [ADDR_W-1:0]           i_addr_b,
    output logic                        o_valid,
    output logic signed [AMP_WIDTH-1:0] o_a,
    output logic signed [AMP_WIDTH-1:0] o_b,
    output logic [ADDR_W-1:0]           o_addr_a,
    output logic [ADDR_W-1:0]           o_addr_b,
    output logic                        o_busy
);

    localparam int SW = AMP_WIDTH + 1;
    localparam int PW = AMP_WIDTH + 18;
    localparam logic signed [PW-1:0] QMAX = $signed((PW'(1) << (AMP_WIDTH - 1)) - PW'(1));
    localparam logic signed [PW-1:0] QMIN = -QMAX - PW'(1);

    // Round half up, floor shift, saturate to the amplitude range
    function automatic logic signed [AMP_WIDTH-1:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        logic signed [PW-1:0] q;
        t = p + $signed(PW'(ROUND_BIAS));
        q = t >>> SCALE_SH;
        if (q > QMAX) begin
            q = QMAX;
        end else if (q < QMIN) begin
            q = QMIN;
        end
        return AMP_WIDTH'(q);
    endfunction

    logic                        r_v1, r_v2, r_v3;
    logic                        r_sw1, r_sw2;
    logic signed [SW-1:0]        r_sum1, r_dif1;
    logic signed [PW-1:0]        r_psum2, r_pdif2;
    logic signed [AMP_WIDTH-1:0] r_a1, r_b1, r_a2, r_b2, r_a3, r_b3;
    logic [ADDR_W-1:0]           r_aa1, r_ab1, r_aa2, r_ab2, r_aa3, r_ab3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        // stage 1: sum and difference
        r_sw1  <= i_ctl.swap;
        r_sum1 <= SW'(i_a) + SW'(i_b);
        r_dif1 <= SW'(i_a) - SW'(i_b);
        r_a1   <= i_a;
        r_b1   <= i_b;
        r_aa1  <= i_addr_a;
        r_ab1  <= i_addr_b;
        // stage 2: scale by 1/sqrt2
        r_sw2   <= r_sw1;
        r_psum2 <= PW'(r_sum1) * PW'(INV_ROOT2);
        r_pdif2 <= PW'(r_dif1) * PW'(INV_ROOT2);
        r_a2    <= r_a1;
        r_b2    <= r_b1;
        r_aa2   <= r_aa1;
        r_ab2   <= r_ab1;
        // stage 3: round and saturate, or swap the raw pair
        if (r_sw2) begin
            r_a3 <= r_b2;
            r_b3 <= r_a2;
        end else begin
            r_a3 <= round_sat(r_psum2);
            r_b3 <= round_sat(r_pdif2);
        end
        r_aa3 <= r_aa2;
        r_ab3 <= r_ab2;
    end

    assign o_valid  = r_v3;
    assign o_a      = r_a3;
    assign o_b      = r_b3;
    assign o_addr_a = r_aa3;
    assign o_addr_b = r_ab3;
    assign o_busy   = r_v1 | r_v2 | r_v3;

endmodule

@@ design/rsvg_sqacc.sv @@
module rsvg_sqacc import rsvg_pkg::*; #(
    parameter int AMP_WIDTH = 18,
    parameter int ADDR_W    = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic                                i_valid,
    input  logic signed [AMP_WIDTH-1:0]         i_value,
    input  logic [ADDR_W-1:0]                   i_idx,
    input  logic [2*AMP_WIDTH+ADDR_W-1:0]       i_threshold,
    output t_meas_stat                          o_stat,
    output logic [ADDR_W-1:0]                   o_pick
);

    localparam int SQW  = 2 * AMP_WIDTH;
    localparam int ACCW = 2 * AMP_WIDTH + ADDR_W;

    logic              r_s1_v;
    logic [SQW-1:0]    r_sq;
    logic [ADDR_W-1:0] r_s1_idx;
    logic [ACCW-1:0]   r_acc;
    logic              r_found;
    logic [ADDR_W-1:0] r_pick;
    logic [ACCW-1:0]   n_acc;

    assign n_acc = r_acc + ACCW'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_s1_v  <= 1'b0;
            r_acc   <= '0;
            r_found <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
            // accumulate until the threshold is reached, then hold
            if (r_s1_v && !r_found) begin
                r_acc <= n_acc;
                if (n_acc >= i_threshold) begin
                    r_found <= 1'b1;
                    r_pick  <= r_s1_idx;
                end
            end
        end
        r_sq     <= $unsigned(SQW'(i_value) * SQW'(i_value));
        r_s1_idx <= i_idx;
    end

    assign o_stat.found = r_found;
    assign o_stat.busy  = r_s1_v;
    assign o_pick       = r_pick;

endmodule

@@ design/real_state_vector_gate_engine_unit.sv @@
// Channel  Dir  Beat contents
// i_op     in   opcode, qubit_a, qubit_b, random_fraction, read_index
// o_res    out  measured_index, amplitude, status (one beat per i_op beat)
// i_cfg    in   qubit_count write (i_cfg_we, i_cfg_wdata)
//
// Measure ends with a collapse sweep over the whole amplitude memory, and init
// sweeps the whole memory as well. The single write and single read port of
// the amplitude memory set how long each opcode takes.
// Reset starts a clearing pass of the whole memory; i_op is not ready until
// it ends. i_op is taken while a finished result still waits in the output
// register; a stall on o_res only holds the next result back.
module real_state_vector_gate_engine_unit import rsvg_pkg::*; #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_WIDTH  = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rsvg_op_if.sink          i_op,
    rsvg_res_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int AW     = MAX_QUBITS;
    localparam int PB     = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
    localparam int FRAC   = AMP_WIDTH - 2;
    localparam int ACCW   = 2 * AMP_WIDTH + AW;
    localparam int THR_SH = 2 * FRAC - RAND_W;
    localparam logic [AMP_WIDTH-1:0] AMP_ONE = AMP_WIDTH'(1) << FRAC;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PAIR, S_PDRAIN, S_MEAS, S_MDRAIN, S_READ, S_RDDAT, S_DONE
    } t_state;

    // Place a bit at position pos, moving the bits at and above it up by one
    function automatic logic [AW-1:0] ins_bit(input logic [AW-1:0] v,
                                             input logic [PB-1:0] pos,
                                             input logic b);
        logic [AW-1:0] m;
        m = (AW'(1) << pos) - AW'(1);
        return ((v & ~m) << 1) | (AW'(b) << pos) | (v & m);
    endfunction

    t_state                      r_state, n_state;
    logic [CFG_W-1:0]            r_qubit_count;
    logic [AW-1:0]               r_addr;
    logic [AW-1:0]               r_one_idx;
    logic                        r_clr_resp;
    logic [AW-1:0]               r_dim_last;
    logic [AW-1:0]               r_pair;
    logic [AW-1:0]               r_last_pair;
    logic                        r_ph;
    logic                        r_cnot;
    logic                        r_meas_mode;
    logic [PB-1:0]               r_lo_pos, r_hi_pos;
    logic                        r_lo_bit, r_hi_bit;
    logic [AW-1:0]               r_pbit;
    logic [ACCW-1:0]             r_thr;
    logic                        r_rv, r_rph;
    logic [AW-1:0]               r_raddr;
    logic signed [AMP_WIDTH-1:0] r_a_val;
    logic [AW-1:0]               r_a_addr;
    logic                        r_wb_pend;
    logic [AW-1:0]               r_wb_addr;
    logic signed [AMP_WIDTH-1:0] r_wb_data;
    logic [IDX_W-1:0]            r_res_midx;
    logic signed [OUT_AMP_W-1:0] r_res_amp;
    logic                        r_res_status;
    logic                        r_out_valid;
    logic [IDX_W-1:0]            r_out_midx;
    logic signed [OUT_AMP_W-1:0] r_out_amp;
    logic                        r_out_status;

    logic [QN_W-1:0]             n_eff, qa5, qb5;
    logic [AW:0]                 dim_sh;
    logic [AW-1:0]               dim_last;
    logic [PB-1:0]               pos_a, pos_b;
    logic                        bad_a, bad_b, a_below_b;
    logic                        in_fire, out_free, issue;
    logic [AW-1:0]               base1, base, rd_addr;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [AMP_WIDTH-1:0]        mem_wdata;
    logic signed [AMP_WIDTH-1:0] rd_data;
    t_bf_ctl                     bf_ctl;
    logic                        bf_valid, bf_busy;
    logic signed [AMP_WIDTH-1:0] bf_a, bf_b;
    logic [AW-1:0]               bf_addr_a, bf_addr_b;
    t_meas_stat                  st;
    logic [AW-1:0]               sq_pick;
    logic [AW-1:0]               m_pick;

    // Effective qubit count and derived positions
    always_comb begin
        if (r_qubit_count < CFG_W'(QN_MIN)) begin
            n_eff = QN_W'(QN_MIN);
        end else if (QN_W'(r_qubit_count) > QN_W'(MAX_QUBITS)) begin
            n_eff = QN_W'(MAX_QUBITS);
        end else begin
            n_eff = QN_W'(r_qubit_count);
        end
        qa5       = QN_W'(i_op.qubit_a);
        qb5       = QN_W'(i_op.qubit_b);
        dim_sh    = (AW + 1)'(1) << n_eff;
        dim_last  = AW'(dim_sh - (AW + 1)'(1));
        pos_a     = PB'(n_eff - qa5 - QN_W'(1));
        pos_b     = PB'(n_eff - qb5 - QN_W'(1));
        bad_a     = (qa5 >= n_eff);
        bad_b     = (qb5 >= n_eff) || (qa5 == qb5);
        a_below_b = (pos_a < pos_b);
    end

    assign in_fire  = i_op.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_res.ready;
    assign issue    = (r_state == S_PAIR) || ((r_state == S_MEAS) && !st.found);
    assign m_pick   = st.found ? sq_pick : r_dim_last;

    // Pair addresses for the current pair count
    always_comb begin
        base1 = ins_bit(r_pair, r_lo_pos, r_lo_bit);
        base  = r_cnot ? ins_bit(base1, r_hi_pos, r_hi_bit) : base1;
        if (r_state == S_PAIR) begin
            rd_addr = r_ph ? (base | r_pbit) : base;
        end else begin
            rd_addr = r_addr;
        end
    end

    // Write port: clear sweep, or first then second value of each pair
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_wdata = (r_addr == r_one_idx) ? AMP_ONE : '0;
        end else if (bf_valid) begin
            mem_we    = 1'b1;
            mem_waddr = bf_addr_a;
            mem_wdata = bf_a;
        end else if (r_wb_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_wb_addr;
            mem_wdata = r_wb_data;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (&r_addr) begin
                    n_state = r_clr_resp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_op.opcode)
                        OP_INIT:     n_state = S_CLEAR;
                        OP_HADAMARD: n_state = bad_a ? S_DONE : S_PAIR;
                        OP_CNOT:     n_state = (bad_a || bad_b) ? S_DONE : S_PAIR;
                        OP_MEASURE:  n_state = S_MEAS;
                        OP_READ:     n_state = S_READ;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_PAIR: begin
                if (r_ph && (r_pair == r_last_pair)) begin
                    n_state = S_PDRAIN;
                end
            end
            S_PDRAIN: begin
                if (!r_rv && !bf_busy && !r_wb_pend) begin
                    n_state = S_DONE;
                end
            end
            S_MEAS: begin
                if (st.found || (r_addr == r_dim_last)) begin
                    n_state = S_MDRAIN;
                end
            end
            S_MDRAIN: begin
                if (!r_rv && !st.busy) begin
                    n_state = S_CLEAR;
                end
            end
            S_READ:  n_state = S_RDDAT;
            S_RDDAT: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_qubit_count <= QUBIT_COUNT_RESET;
            r_addr        <= '0;
            r_one_idx     <= '0;
            r_clr_resp    <= 1'b0;
            r_rv          <= 1'b0;
            r_wb_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_meas_mode   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rv      <= issue;
            r_wb_pend <= bf_valid;
            if (i_cfg_we) begin
                r_qubit_count <= i_cfg_wdata;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_meas_mode <= (i_op.opcode == OP_MEASURE);
                        r_addr      <= '0;
                        if (i_op.opcode == OP_INIT) begin
                            r_one_idx  <= '0;
                            r_clr_resp <= 1'b1;
                        end
                        if (i_op.opcode == OP_READ) begin
                            r_addr <= AW'(i_op.read_index);
                        end
                    end
                end
                S_MEAS: begin
                    r_addr <= r_addr + AW'(1);
                end
                S_MDRAIN: begin
                    if (!r_rv && !st.busy) begin
                        r_one_idx  <= m_pick;
                        r_addr     <= '0;
                        r_clr_resp <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Datapath registers, no reset
        r_rph   <= r_ph;
        r_raddr <= rd_addr;
        if (r_rv && !r_meas_mode && !r_rph) begin
            r_a_val  <= rd_data;
            r_a_addr <= r_raddr;
        end
        r_wb_addr <= bf_addr_b;
        r_wb_data <= bf_b;

        if (in_fire) begin
            r_res_midx   <= '0;
            r_res_amp    <= '0;
            r_res_status <= 1'b0;
            r_dim_last   <= dim_last;
            r_pair       <= '0;
            r_ph         <= 1'b0;
            r_thr        <= ACCW'(i_op.random_fraction) << THR_SH;
            if (i_op.opcode == OP_HADAMARD) begin
                r_res_status <= bad_a;
                r_cnot       <= 1'b0;
                r_lo_pos     <= pos_a;
                r_lo_bit     <= 1'b0;
                r_pbit       <= AW'(1) << pos_a;
                r_last_pair  <= dim_last >> 1;
            end else if (i_op.opcode == OP_CNOT) begin
                r_res_status <= bad_a || bad_b;
                r_cnot       <= 1'b1;
                // insert the lower position first; the control bit is set
                r_lo_pos     <= a_below_b ? pos_a : pos_b;
                r_lo_bit     <= a_below_b;
                r_hi_pos     <= a_below_b ? pos_b : pos_a;
                r_hi_bit     <= !a_below_b;
                r_pbit       <= AW'(1) << pos_b;
                r_last_pair  <= dim_last >> 2;
            end
        end else if (r_state == S_PAIR) begin
            r_ph <= !r_ph;
            if (r_ph) begin
                r_pair <= r_pair + AW'(1);
            end
        end
        if ((r_state == S_MDRAIN) && !r_rv && !st.busy) begin
            r_res_midx <= IDX_W'(m_pick);
        end
        if (r_state == S_RDDAT) begin
            r_res_amp <= OUT_AMP_W'(rd_data);
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_midx   <= r_res_midx;
            r_out_amp    <= r_res_amp;
            r_out_status <= r_res_status;
        end
    end

    assign i_op.ready           = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.measured_index = r_out_midx;
    assign o_res.amplitude      = r_out_amp;
    assign o_res.status         = r_out_status;

    assign bf_ctl.valid = r_rv && !r_meas_mode && r_rph;
    assign bf_ctl.swap  = r_cnot;

    rsvg_store #(
        .ADDR_W (AW),
        .DATA_W (AMP_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rsvg_butterfly #(
        .AMP_WIDTH (AMP_WIDTH),
        .ADDR_W    (AW)
    ) u_butterfly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (bf_ctl),
        .i_a      (r_a_val),
        .i_b      (rd_data),
        .i_addr_a (r_a_addr),
        .i_addr_b (r_raddr),
        .o_valid  (bf_valid),
        .o_a      (bf_a),
        .o_b      (bf_b),
        .o_addr_a (bf_addr_a),
        .o_addr_b (bf_addr_b),
        .o_busy   (bf_busy)
    );

    rsvg_sqacc #(
        .AMP_WIDTH (AMP_WIDTH),
        .ADDR_W    (AW)
    ) u_sqacc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (in_fire && (i_op.opcode == OP_MEASURE)),
        .i_valid     (r_rv && r_meas_mode),
        .i_value     (rd_data),
        .i_idx       (r_raddr),
        .i_threshold (r_thr),
        .o_stat      (st),
        .o_pick      (sq_pick)
    );

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("memory written while idle");

    a_write_port_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bf_valid |-> !r_wb_pend)
        else $error("pair write collides with pending second write");

    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.ready |-> (!r_rv && !st.busy && !bf_busy && !r_wb_pend))
        else $error("ready while reads or writes still in flight");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && r_clr_resp) |-> (r_one_idx <= r_dim_last))
        else $error("collapse index beyond active vector");

endmodule

@@ test/real_state_vector_gate_engine_unit_test.sv @@
`timescale 1ns / 1ps

module real_state_vector_gate_engine_unit_test;
    import rsvg_pkg::*;

    localparam int MAX_Q       = 10;
    localparam int AMP_W       = 18;
    localparam int STORE_DEPTH = 1 << MAX_Q;
    localparam int FRAC_W      = AMP_W - 2;

    localparam longint AMP_ONE       = longint'(1) << FRAC_W;
    localparam longint AMP_MAX       = (longint'(1) << (AMP_W - 1)) - 1;
    localparam longint AMP_MIN       = -(longint'(1) << (AMP_W - 1));
    localparam longint INV_SQRT2_Q16 = 46341;
    localparam longint HALF_LSB      = 32768;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [QUBIT_W-1:0] qubit_a;
        logic [QUBIT_W-1:0] qubit_b;
        logic [RAND_W-1:0]  random_fraction;
        logic [IDX_W-1:0]   read_index;
    } op_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]            measured_index;
        logic signed [OUT_AMP_W-1:0] amplitude;
        logic                        status;
    } res_beat_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    rsvg_op_if  op_if();
    rsvg_res_if res_if();

    real_state_vector_gate_engine_unit #(
        .MAX_QUBITS(MAX_Q),
        .AMP_WIDTH (AMP_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Shadow of the amplitude store and the qubit_count register
    logic signed [AMP_W-1:0] amp_model [STORE_DEPTH];
    logic [CFG_W-1:0]        model_qubits;

    res_beat_t pending_results[$];
    res_beat_t next_want;

    bit steady_flow;
    int mismatches;
    int beats_sent;
    int results_checked;
    int measures_sent;
    int rejected_sent;
    int count_writes;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int active_qubit_count();
        int n;
        n = model_qubits;
        if (n < QN_MIN) n = QN_MIN;
        if (n > MAX_Q) n = MAX_Q;
        return n;
    endfunction

    function automatic void collapse_to(input int index);
        for (int i = 0; i < STORE_DEPTH; i++) amp_model[i] = '0;
        amp_model[index] = AMP_ONE[AMP_W-1:0];
    endfunction

    // multiply by 1/sqrt2, round half up, saturate
    function automatic logic signed [AMP_W-1:0] scale_by_inv_root2(input longint sum);
        longint prod;
        prod = (sum * INV_SQRT2_Q16 + HALF_LSB) >>> 16;
        if (prod > AMP_MAX) prod = AMP_MAX;
        else if (prod < AMP_MIN) prod = AMP_MIN;
        return prod[AMP_W-1:0];
    endfunction

    function automatic res_beat_t apply_gate_op(input op_beat_t b);
        res_beat_t r;
        int n, dim, qa, qb, bit_a, bit_b, pick;
        longint x, y, acc, threshold;
        logic signed [AMP_W-1:0] held;
        r = '0;
        n = active_qubit_count();
        dim = 1 << n;
        qa = b.qubit_a;
        qb = b.qubit_b;
        case (b.opcode)
            OP_INIT: collapse_to(0);
            OP_HADAMARD: begin
                if (qa >= n) begin
                    r.status = 1'b1;
                end else begin
                    bit_a = 1 << (n - 1 - qa);
                    for (int i = 0; i < dim; i++) begin
                        if ((i & bit_a) == 0) begin
                            x = amp_model[i];
                            y = amp_model[i | bit_a];
                            amp_model[i]         = scale_by_inv_root2(x + y);
                            amp_model[i | bit_a] = scale_by_inv_root2(x - y);
                        end
                    end
                end
            end
            OP_CNOT: begin
                if (qa >= n || qb >= n || qa == qb) begin
                    r.status = 1'b1;
                end else begin
                    bit_a = 1 << (n - 1 - qa);
                    bit_b = 1 << (n - 1 - qb);
                    for (int i = 0; i < dim; i++) begin
                        if ((i & bit_a) != 0 && (i & bit_b) == 0) begin
                            held               = amp_model[i];
                            amp_model[i]         = amp_model[i | bit_b];
                            amp_model[i | bit_b] = held;
                        end
                    end
                end
            end
            OP_MEASURE: begin
                threshold = longint'(b.random_fraction) << (2 * FRAC_W - RAND_W);
                acc = 0;
                pick = dim - 1;
                for (int i = 0; i < dim; i++) begin
                    x = amp_model[i];
                    acc += x * x;
                    if (acc >= threshold) begin
                        pick = i;
                        break;
                    end
                end
                collapse_to(pick);
                r.measured_index = pick[IDX_W-1:0];
            end
            OP_READ: r.amplitude = amp_model[b.read_index];
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns, result %0d: %s", $time, results_checked, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                next_want = pending_results.pop_front();
                if (res_if.measured_index !== next_want.measured_index)
                    report_mismatch($sformatf("measured_index %0d, expected %0d",
                        res_if.measured_index, next_want.measured_index));
                if (res_if.amplitude !== next_want.amplitude)
                    report_mismatch($sformatf("amplitude %0d, expected %0d",
                        $signed(res_if.amplitude), $signed(next_want.amplitude)));
                if (res_if.status !== next_want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        res_if.status, next_want.status));
            end
            results_checked++;
        end
    end

    // result stalls: about a third of cycles, none while steady_flow is set
    always @(posedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else res_if.ready <= steady_flow || ($urandom_range(99) >= 32);
    end

    // ---------------------------------------------------------------- stimulus

    function automatic op_beat_t random_fill();
        op_beat_t b;
        b.opcode          = $urandom_range(7);
        b.qubit_a         = $urandom_range(15);
        b.qubit_b         = $urandom_range(15);
        b.random_fraction = $urandom_range(16'hffff);
        b.read_index      = $urandom_range(STORE_DEPTH - 1);
        return b;
    endfunction

    function automatic op_beat_t make_beat(input logic [OP_W-1:0] op, input int qa, input int qb,
                                           input int frac, input int index);
        op_beat_t b;
        b.opcode          = op;
        b.qubit_a         = qa[QUBIT_W-1:0];
        b.qubit_b         = qb[QUBIT_W-1:0];
        b.random_fraction = frac[RAND_W-1:0];
        b.read_index      = index[IDX_W-1:0];
        return b;
    endfunction

    task automatic send_op(input op_beat_t b);
        res_beat_t want;
        while (!steady_flow && $urandom_range(99) < 32) begin
            op_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        op_if.valid           <= 1'b1;
        op_if.opcode          <= b.opcode;
        op_if.qubit_a         <= b.qubit_a;
        op_if.qubit_b         <= b.qubit_b;
        op_if.random_fraction <= b.random_fraction;
        op_if.read_index      <= b.read_index;
        @(posedge i_clk);
        while (!op_if.ready) @(posedge i_clk);
        want = apply_gate_op(b);
        pending_results.push_back(want);
        beats_sent++;
        if (b.opcode == OP_MEASURE) measures_sent++;
        if (want.status) rejected_sent++;
    endtask

    task automatic wait_for_results();
        op_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // let any trailing collapse sweep finish before touching the register
    task automatic set_qubit_count(input logic [CFG_W-1:0] value);
        wait_for_results();
        repeat (STORE_DEPTH + 16) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_qubits = value;
        count_writes++;
    endtask

    // init most of the time, a run of gates and reads with some noise, then a measurement
    task automatic run_circuit(input int n, input int gate_count, inout int good);
        op_beat_t b;
        int pick, qa;
        if ($urandom_range(9) < 8) begin
            b = random_fill();
            b.opcode = OP_INIT;
            send_op(b);
            good++;
        end
        for (int k = 0; k < gate_count; k++) begin
            b = random_fill();
            pick = $urandom_range(99);
            qa = $urandom_range(n - 1);
            if (pick < 40) begin
                b.opcode  = OP_HADAMARD;
                b.qubit_a = qa;
                good++;
            end else if (pick < 65) begin
                b.opcode  = OP_CNOT;
                b.qubit_a = qa;
                b.qubit_b = (qa + 1 + $urandom_range(n - 2)) % n;
                good++;
            end else if (pick < 90) begin
                b.opcode = OP_READ;
                // mostly inside the active vector, sometimes anywhere in the store
                if ($urandom_range(4) != 0) b.read_index = $urandom_range((1 << n) - 1);
                good++;
            end else if (pick < 96) begin
                b.opcode = $urandom_range(1) ? OP_HADAMARD : OP_CNOT;
                case ($urandom_range(2))
                    0: b.qubit_a = $urandom_range(15, n);
                    1: b.qubit_b = $urandom_range(15, n);
                    default: begin
                        b.qubit_a = qa;
                        b.qubit_b = qa;
                    end
                endcase
                if (b.opcode == OP_HADAMARD) b.qubit_a = $urandom_range(15, n);
            end else begin
                b.opcode = $urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST);
            end
            send_op(b);
        end
        b = random_fill();
        b.opcode = OP_MEASURE;
        send_op(b);
        good++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_op(make_beat(OP_READ, 0, 0, 0, 0));
        send_op(make_beat(OP_READ, 15, 15, 16'hffff, STORE_DEPTH - 1));
    endtask

    // runs at the reset qubit count of three
    task automatic test_directed_gates();
        send_op(make_beat(OP_HADAMARD, 0, 0, 0, 0));
        send_op(make_beat(OP_READ, 0, 0, 0, 0));
        send_op(make_beat(OP_READ, 0, 0, 0, 4));
        send_op(make_beat(OP_HADAMARD, 2, 0, 0, 0));
        send_op(make_beat(OP_HADAMARD, 3, 0, 0, 0));
        send_op(make_beat(OP_HADAMARD, 15, 15, 16'hffff, STORE_DEPTH - 1));
        send_op(make_beat(OP_CNOT, 0, 2, 0, 0));
        send_op(make_beat(OP_CNOT, 2, 0, 0, 0));
        send_op(make_beat(OP_CNOT, 1, 1, 0, 0));
        send_op(make_beat(OP_CNOT, 3, 0, 0, 0));
        send_op(make_beat(OP_CNOT, 0, 15, 0, 0));
        // zero threshold lands on index zero
        send_op(make_beat(OP_MEASURE, 0, 0, 0, 0));
        send_op(make_beat(OP_INIT, 0, 0, 0, 0));
        send_op(make_beat(OP_HADAMARD, 0, 0, 0, 0));
        send_op(make_beat(OP_HADAMARD, 1, 0, 0, 0));
        send_op(make_beat(OP_HADAMARD, 2, 0, 0, 0));
        // the running total first reaches this at the last index, so the last index wins
        send_op(make_beat(OP_MEASURE, 0, 0, 16'hffff, 0));
        send_op(make_beat(OP_HADAMARD, 2, 0, 0, 0));
        send_op(make_beat(OP_READ, 0, 0, 0, 7));
        send_op(make_beat(OP_READ, 0, 0, 0, 512));
        send_op(make_beat(OP_SPARE_FIRST, 9, 9, 16'hffff, STORE_DEPTH - 1));
        send_op(make_beat(OP_SPARE_LAST, 0, 0, 0, 0));
        send_op(make_beat(OP_READ, 0, 0, 0, STORE_DEPTH - 1));
    endtask

    task automatic test_drain_pause();
        op_beat_t b;
        steady_flow = 1'b1;
        repeat (4) begin
            b = random_fill();
            b.opcode  = OP_HADAMARD;
            b.qubit_a = $urandom_range(2);
            send_op(b);
        end
        // hold off until every result is back
        wait_for_results();
        b = random_fill();
        b.opcode = OP_READ;
        send_op(b);
        b = random_fill();
        b.opcode = OP_MEASURE;
        send_op(b);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_circuits();
        int qubits_at [10];
        int items_at [10];
        int good;
        qubits_at = '{3, 0, 2, 4, 6, 10, 15, 1, 8, 5};
        items_at  = '{90, 60, 60, 80, 70, 35, 20, 40, 50, 75};
        for (int p = 0; p < 10; p++) begin
            set_qubit_count(qubits_at[p][CFG_W-1:0]);
            steady_flow = (p == 3);
            good = 0;
            while (good < items_at[p])
                run_circuit(active_qubit_count(), $urandom_range(10, 2), good);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        op_if.valid           = 1'b0;
        op_if.opcode          = '0;
        op_if.qubit_a         = '0;
        op_if.qubit_b         = '0;
        op_if.random_fraction = '0;
        op_if.read_index      = '0;
        res_if.ready          = 1'b0;
        steady_flow           = 1'b0;
        model_qubits          = QUBIT_COUNT_RESET;
        collapse_to(0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_gates();
        test_drain_pause();
        test_random_circuits();

        wait_for_results();
        repeat (STORE_DEPTH + 16) @(posedge i_clk);
        $display("sent %0d op beats (%0d measurements, %0d rejected gates) over %0d qubit counts",
                 beats_sent, measures_sent, rejected_sent, count_writes + 1);
        $display("checked %0d result beats, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
